>>> sv/gsa_pkg.sv
// Shared types, constants and operation codes of the generational slot allocator.
package gsa_pkg;

	localparam int SLOT_COUNT = 256;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);
	localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
	localparam int GEN_W      = 32;
	localparam int PAY_W      = 32;
	localparam int HSLOT_W    = 8;

	localparam logic [1:0] FN_ALLOC   = 2'd0;
	localparam logic [1:0] FN_RESOLVE = 2'd1;
	localparam logic [1:0] FN_REMOVE  = 2'd2;
	localparam logic [1:0] FN_CLEAR   = 2'd3;

	localparam logic [GEN_W-1:0] GEN_MAX = {GEN_W{1'b1}};

	typedef struct packed {
		logic [1:0]         func;
		logic [HSLOT_W-1:0] slot;
		logic [GEN_W-1:0]   generation;
		logic [PAY_W-1:0]   payload;
		logic               payload_present;
	} req_t;

	typedef struct packed {
		logic               ok;
		logic [HSLOT_W-1:0] out_slot;
		logic [GEN_W-1:0]   out_generation;
		logic [PAY_W-1:0]   out_payload;
	} rsp_t;

	// One row of the handle table.
	typedef struct packed {
		logic [GEN_W-1:0] gen;
		logic [PAY_W-1:0] pay;
		logic             occ;
	} tbl_entry_t;

	// A freed slot together with the generation it will be handed out at.
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [GEN_W-1:0]  gen;
	} stk_entry_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		tbl_entry_t        data;
	} tbl_wr_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		stk_entry_t        data;
	} stk_wr_t;

endpackage

>>> sv/gsa_ram.sv
// Generic single-write, single-read RAM with registered, write-first read data.
module gsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			if (we && (waddr == raddr)) begin
				rdata <= wdata;
			end else begin
				rdata <= mem[raddr];
			end
		end
	end

endmodule

>>> sv/gsa_ctrl.sv
// Operation logic of the allocator: decides each result and the table and stack updates.
module gsa_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  gsa_pkg::req_t                item,
	input  gsa_pkg::tbl_entry_t          tbl_rd,
	input  gsa_pkg::stk_entry_t          stk_rd,
	output gsa_pkg::rsp_t                result,
	output gsa_pkg::tbl_wr_t             tbl_wr,
	output gsa_pkg::stk_wr_t             stk_wr,
	output logic [gsa_pkg::CNT_W-1:0]    depth_nx
);

	logic [gsa_pkg::CNT_W-1:0] free_depth_q;
	logic [gsa_pkg::CNT_W-1:0] slots_used_q;
	logic [gsa_pkg::CNT_W-1:0] depth_d;
	logic [gsa_pkg::CNT_W-1:0] used_d;
	logic                      live;

	// A handle is live when it lies in the used range, is occupied and matches.
	assign live = (gsa_pkg::CNT_W'(item.slot) < slots_used_q)
		&& (tbl_rd.gen == item.generation) && tbl_rd.occ;

	always_comb begin
		result      = '0;
		tbl_wr      = '0;
		stk_wr      = '0;
		depth_d     = free_depth_q;
		used_d      = slots_used_q;
		tbl_wr.addr = item.slot[gsa_pkg::SLOT_W-1:0];
		stk_wr.addr = free_depth_q[gsa_pkg::SLOT_W-1:0];
		unique case (item.func)
			gsa_pkg::FN_ALLOC: begin
				if (item.payload_present) begin
					if (free_depth_q != '0) begin
						depth_d               = free_depth_q - 1'b1;
						tbl_wr.en             = 1'b1;
						tbl_wr.addr           = stk_rd.slot;
						tbl_wr.data.gen       = stk_rd.gen;
						result.ok             = 1'b1;
						result.out_slot       = gsa_pkg::HSLOT_W'(stk_rd.slot);
						result.out_generation = stk_rd.gen;
					end else if (slots_used_q < gsa_pkg::CNT_W'(gsa_pkg::SLOT_COUNT)) begin
						used_d                = slots_used_q + 1'b1;
						tbl_wr.en             = 1'b1;
						tbl_wr.addr           = slots_used_q[gsa_pkg::SLOT_W-1:0];
						tbl_wr.data.gen       = '0;
						result.ok             = 1'b1;
						result.out_slot       = gsa_pkg::HSLOT_W'(slots_used_q);
						result.out_generation = '0;
					end
					tbl_wr.data.pay = item.payload;
					tbl_wr.data.occ = 1'b1;
				end
			end
			gsa_pkg::FN_RESOLVE: begin
				if (live) begin
					result.ok          = 1'b1;
					result.out_payload = tbl_rd.pay;
				end
			end
			gsa_pkg::FN_REMOVE: begin
				if (live) begin
					result.ok       = 1'b1;
					tbl_wr.en       = 1'b1;
					tbl_wr.data.pay = '0;
					tbl_wr.data.occ = 1'b0;
					if (tbl_rd.gen != gsa_pkg::GEN_MAX) begin
						tbl_wr.data.gen = tbl_rd.gen + 1'b1;
						if (free_depth_q < gsa_pkg::CNT_W'(gsa_pkg::SLOT_COUNT)) begin
							stk_wr.en        = 1'b1;
							stk_wr.data.slot = item.slot[gsa_pkg::SLOT_W-1:0];
							stk_wr.data.gen  = tbl_rd.gen + 1'b1;
							depth_d          = free_depth_q + 1'b1;
						end
					end else begin
						// A slot at the last generation is retired until the next clear.
						tbl_wr.data.gen = tbl_rd.gen;
					end
				end
			end
			gsa_pkg::FN_CLEAR: begin
				depth_d = '0;
				used_d  = '0;
			end
			default: begin
			end
		endcase
		tbl_wr.en = tbl_wr.en && fire;
		stk_wr.en = stk_wr.en && fire;
	end

	assign depth_nx = fire ? depth_d : free_depth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_depth_q <= '0;
			slots_used_q <= '0;
		end else if (fire) begin
			free_depth_q <= depth_d;
			slots_used_q <= used_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		free_depth_q <= slots_used_q)
		else $error("free stack deeper than the used range");

	assert property (@(posedge clk) disable iff (!arst_n)
		fire && (item.func == gsa_pkg::FN_CLEAR) |=> (free_depth_q == '0) && (slots_used_q == '0))
		else $error("clear did not empty the table");

	assert property (@(posedge clk) disable iff (!arst_n)
		fire && result.ok && (item.func == gsa_pkg::FN_ALLOC)
		|-> gsa_pkg::CNT_W'(result.out_slot) < used_d)
		else $error("allocated slot outside the used range");

	assert property (@(posedge clk) disable iff (!arst_n)
		stk_wr.en |=> free_depth_q == $past(free_depth_q) + 1'b1)
		else $error("push did not grow the free stack");

endmodule

>>> sv/generational_slot_allocator_unit.sv
// Top level of the generational slot allocator: input stage, table and stack RAMs, result register.
// A request beat accepted at a clock edge waits in the request stage while its table and stack
// rows are read; its response is registered once the response register is free or draining.
// Throughput: one request per cycle while the consumer keeps taking responses; every operation
// is a single read-modify-write of the handle table and the free stack, and reads see the
// previous request's writes directly. Reset: arst_n clears the used count, the free stack
// depth and the valid flags; the RAMs are not cleared, since no entry is used before it is written.
module generational_slot_allocator_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  gsa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output gsa_pkg::rsp_t rsp
);

	// The request stage holds one beat while its table and stack rows are read.
	logic                      s1_valid_q;
	gsa_pkg::req_t             item_s1;
	logic                      s1_fire;
	logic                      req_accept;

	// Response register that parts the request stage from the consumer.
	logic                      rsp_valid_q;
	gsa_pkg::rsp_t             rsp_q;

	gsa_pkg::tbl_entry_t       tbl_rd;
	gsa_pkg::stk_entry_t       stk_rd;
	gsa_pkg::rsp_t             result;
	gsa_pkg::tbl_wr_t          tbl_wr;
	gsa_pkg::stk_wr_t          stk_wr;
	logic [gsa_pkg::CNT_W-1:0] depth_nx;
	logic [gsa_pkg::CNT_W-1:0] stk_top;

	// The beat in the request stage retires whenever the response register is free or draining.
	assign s1_fire    = s1_valid_q && (!rsp_valid_q || rsp_ready);
	assign req_ready  = !s1_valid_q || s1_fire;
	assign req_accept = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req_ready) begin
			s1_valid_q <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			item_s1 <= req;
		end
	end

	// The stack top is addressed from the depth that the retiring beat leaves behind, so a
	// pop right after a push or another pop finds the right row.
	assign stk_top = depth_nx - 1'b1;

	gsa_ram #(
		.WIDTH ($bits(gsa_pkg::tbl_entry_t)),
		.DEPTH (gsa_pkg::SLOT_COUNT)
	) u_tbl_ram (
		.clk   (clk),
		.we    (tbl_wr.en),
		.waddr (tbl_wr.addr),
		.wdata (tbl_wr.data),
		.re    (req_accept),
		.raddr (req.slot[gsa_pkg::SLOT_W-1:0]),
		.rdata (tbl_rd)
	);

	gsa_ram #(
		.WIDTH ($bits(gsa_pkg::stk_entry_t)),
		.DEPTH (gsa_pkg::SLOT_COUNT)
	) u_stk_ram (
		.clk   (clk),
		.we    (stk_wr.en),
		.waddr (stk_wr.addr),
		.wdata (stk_wr.data),
		.re    (req_accept),
		.raddr (stk_top[gsa_pkg::SLOT_W-1:0]),
		.rdata (stk_rd)
	);

	gsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (s1_fire),
		.item     (item_s1),
		.tbl_rd   (tbl_rd),
		.stk_rd   (stk_rd),
		.result   (result),
		.tbl_wr   (tbl_wr),
		.stk_wr   (stk_wr),
		.depth_nx (depth_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for generational_slot_allocator_unit, with a handle-table mirror.
module tb;

	// Every block input starts at a known value at time zero.
	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_ready;
	gsa_pkg::req_t req       = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	gsa_pkg::rsp_t rsp;

	generational_slot_allocator_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// 20 ns clock: 10 ns low, then 10 ns high.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Mirror of the handle table. The arrays are two-state so that an entry the
	// block has never written reads as zero here, but the stimulus never relies
	// on it: a slot at or above the used count is never looked up.
	bit [gsa_pkg::GEN_W-1:0]  mirror_gen  [gsa_pkg::SLOT_COUNT];
	bit [gsa_pkg::PAY_W-1:0]  mirror_pay  [gsa_pkg::SLOT_COUNT];
	bit                       mirror_occ  [gsa_pkg::SLOT_COUNT];
	bit [gsa_pkg::SLOT_W-1:0] mirror_free [gsa_pkg::SLOT_COUNT];
	int unsigned              mirror_used     = 0;
	int unsigned              mirror_free_cnt = 0;

	// Replies the block still owes us, oldest first.
	gsa_pkg::rsp_t table_replies [$];

	int unsigned mismatch_count = 0;

	// Idle percentages for the two sides, and a long receiver hold-off counter.
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_left     = 0;

	// Apply one operation to the mirror and return the reply it must produce.
	function automatic gsa_pkg::rsp_t table_apply(gsa_pkg::req_t r);
		gsa_pkg::rsp_t o;
		int unsigned   t;
		bit            got;
		bit            live;
		o    = '0;
		t    = 0;
		got  = 1'b0;
		live = 1'b0;
		// A handle is live only inside the used range, occupied, and at the
		// slot's current generation. The range test comes first so that
		// nothing outside the written part of the table is consulted.
		if (r.slot < mirror_used)
			live = mirror_occ[r.slot] && (mirror_gen[r.slot] == r.generation);
		case (r.func)
			gsa_pkg::FN_ALLOC: begin
				// A null payload fails before the free stack is looked at.
				if (r.payload_present) begin
					if (mirror_free_cnt > 0) begin
						// Most recently freed slot first; its generation was
						// already bumped by the remove that freed it.
						mirror_free_cnt--;
						t   = 32'(mirror_free[mirror_free_cnt]);
						got = 1'b1;
					end else if (mirror_used < gsa_pkg::SLOT_COUNT) begin
						// Fresh slot, always starting at generation zero.
						t = mirror_used;
						mirror_used++;
						mirror_gen[t] = '0;
						got = 1'b1;
					end
				end
				if (got) begin
					mirror_pay[t]    = r.payload;
					mirror_occ[t]    = 1'b1;
					o.ok             = 1'b1;
					o.out_slot       = t[gsa_pkg::HSLOT_W-1:0];
					o.out_generation = mirror_gen[t];
				end
			end
			gsa_pkg::FN_RESOLVE: begin
				if (live) begin
					o.ok          = 1'b1;
					o.out_payload = mirror_pay[r.slot];
				end
			end
			gsa_pkg::FN_REMOVE: begin
				if (live) begin
					mirror_occ[r.slot] = 1'b0;
					mirror_pay[r.slot] = '0;
					// At the top generation the slot is retired: it stays
					// empty and is not pushed, so only a clear brings it back.
					if (mirror_gen[r.slot] != gsa_pkg::GEN_MAX) begin
						mirror_gen[r.slot]++;
						if (mirror_free_cnt < gsa_pkg::SLOT_COUNT) begin
							mirror_free[mirror_free_cnt] = r.slot[gsa_pkg::SLOT_W-1:0];
							mirror_free_cnt++;
						end
					end
					o.ok = 1'b1;
				end
			end
			default: begin
				// Clear forgets every slot; the reply is all zeros.
				mirror_used     = 0;
				mirror_free_cnt = 0;
			end
		endcase
		return o;
	endfunction

	function automatic gsa_pkg::req_t op_req(logic [1:0] func,
			logic [gsa_pkg::HSLOT_W-1:0] slot, logic [gsa_pkg::GEN_W-1:0] gen,
			logic [gsa_pkg::PAY_W-1:0] pay, logic present);
		gsa_pkg::req_t r;
		r.func            = func;
		r.slot            = slot;
		r.generation      = gen;
		r.payload         = pay;
		r.payload_present = present;
		return r;
	endfunction

	// A resolve or remove aimed at a slot in the used range (any slot while that range is empty),
	// mostly with its current generation, sometimes one step off or random (stale handles).
	// The unused payload fields carry random bits too.
	function automatic gsa_pkg::req_t handle_op(logic [1:0] func);
		logic [gsa_pkg::HSLOT_W-1:0] s;
		logic [gsa_pkg::GEN_W-1:0]   g;
		if (mirror_used == 0) begin
			s = gsa_pkg::HSLOT_W'($urandom_range(gsa_pkg::SLOT_COUNT - 1));
			g = $urandom;
		end else begin
			s = gsa_pkg::HSLOT_W'($urandom_range(mirror_used - 1));
			g = mirror_gen[s];
			case ($urandom_range(7))
				0: g = g - 1;
				1: g = g + 1;
				2: g = $urandom;
				default: ;
			endcase
		end
		return op_req(func, s, g, $urandom, 1'($urandom_range(1)));
	endfunction

	// Mostly well-formed traffic with random content, plus a share of noise.
	function automatic gsa_pkg::req_t random_op();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 40)
			return op_req(gsa_pkg::FN_ALLOC, gsa_pkg::HSLOT_W'($urandom), $urandom,
				$urandom, $urandom_range(19) != 0);
		else if (pick < 62)
			return handle_op(gsa_pkg::FN_RESOLVE);
		else if (pick < 84)
			return handle_op(gsa_pkg::FN_REMOVE);
		else if (pick < 85)
			return op_req(gsa_pkg::FN_CLEAR, gsa_pkg::HSLOT_W'($urandom), $urandom,
				$urandom, 1'($urandom_range(1)));
		// Noise: any slot and any generation, including out-of-range slots.
		return op_req(2'($urandom_range(2)), gsa_pkg::HSLOT_W'($urandom), $urandom,
			$urandom, 1'($urandom_range(1)));
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= 100)
			$display("mismatch %s at %0t ns: got %h, expected %h", field, $time, got, want);
	endtask

	task automatic set_idle(int unsigned send_pct, int unsigned recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	// Send one request beat. Inputs change only at the falling edge, and the
	// handshake is sampled at the rising edge. The mirror is updated at the
	// accepting edge, so the next request is built from up-to-date state.
	task automatic send_op(gsa_pkg::req_t r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		table_replies = {table_replies, table_apply(r)};
	endtask

	// Receiver side: a long hold-off when one is pending, else random stalls.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Every response beat is checked field by field against the oldest reply owed.
	always @(posedge clk) begin : check_replies
		gsa_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (table_replies.size() == 0) begin
				report_mismatch("unexpected response beat, ok", 32'(rsp.ok), 32'd0);
			end else begin
				want = table_replies.pop_front();
				if (rsp.ok !== want.ok)
					report_mismatch("ok", 32'(rsp.ok), 32'(want.ok));
				if (rsp.out_slot !== want.out_slot)
					report_mismatch("out_slot", 32'(rsp.out_slot), 32'(want.out_slot));
				if (rsp.out_generation !== want.out_generation)
					report_mismatch("out_generation", rsp.out_generation, want.out_generation);
				if (rsp.out_payload !== want.out_payload)
					report_mismatch("out_payload", rsp.out_payload, want.out_payload);
			end
		end
	end

	// Empty table: null payload, lookups on an empty used range, the payload
	// extremes, hits, a wrong generation and a slot past the used range.
	task automatic test_alloc_resolve_basics();
		send_op(op_req(gsa_pkg::FN_ALLOC,   8'd0,  '0, '1, 1'b0));
		send_op(op_req(gsa_pkg::FN_RESOLVE, 8'd0,  '0, '0, 1'b1));
		send_op(op_req(gsa_pkg::FN_REMOVE,  8'd0,  '0, '0, 1'b0));
		send_op(op_req(gsa_pkg::FN_ALLOC,   8'd0,  '0, '0, 1'b1));
		send_op(op_req(gsa_pkg::FN_ALLOC,   8'hff, '1, '1, 1'b1));
		send_op(op_req(gsa_pkg::FN_RESOLVE, 8'd0,  '0, '1, 1'b0));
		send_op(op_req(gsa_pkg::FN_RESOLVE, 8'd1,  '0, '0, 1'b1));
		send_op(op_req(gsa_pkg::FN_RESOLVE, 8'd1,  gsa_pkg::GEN_MAX, '0, 1'b1));
		send_op(op_req(gsa_pkg::FN_RESOLVE, 8'hff, '0, '0, 1'b1));
	endtask

	// Remove, stale and empty handles, then reuse from the free stack in LIFO
	// order with bumped generations. Reaching a retired slot would take four
	// billion removes of one slot, so only a remove at the top generation
	// value is tried here, which must miss as stale.
	task automatic test_remove_and_reuse();
		send_op(op_req(gsa_pkg::FN_REMOVE,  8'd0, 32'd0, '0, 1'b0));
		send_op(op_req(gsa_pkg::FN_RESOLVE, 8'd0, 32'd0, '0, 1'b0));
		send_op(op_req(gsa_pkg::FN_RESOLVE, 8'd0, 32'd1, '0, 1'b0));
		send_op(op_req(gsa_pkg::FN_REMOVE,  8'd0, 32'd1, '0, 1'b0));
		send_op(op_req(gsa_pkg::FN_ALLOC,   8'd0, '0,    32'ha5a5_a5a5, 1'b1));
		send_op(op_req(gsa_pkg::FN_REMOVE,  8'd1, 32'd0, '0, 1'b0));
		send_op(op_req(gsa_pkg::FN_REMOVE,  8'd0, 32'd1, '0, 1'b0));
		send_op(op_req(gsa_pkg::FN_ALLOC,   8'd0, '0,    32'h5a5a_5a5a, 1'b1));
		send_op(op_req(gsa_pkg::FN_ALLOC,   8'd0, '0,    32'h0123_4567, 1'b1));
		send_op(op_req(gsa_pkg::FN_REMOVE,  8'd0, gsa_pkg::GEN_MAX, '0, 1'b0));
	endtask

	// After a clear, old handles miss and slot numbering restarts at zero.
	task automatic test_clear();
		send_op(op_req(gsa_pkg::FN_CLEAR,   8'h5a, 32'hdead_beef, 32'hcafe_f00d, 1'b1));
		send_op(op_req(gsa_pkg::FN_RESOLVE, 8'd0,  32'd2, '0, 1'b0));
		send_op(op_req(gsa_pkg::FN_ALLOC,   8'd0,  '0,    32'h8000_0001, 1'b1));
	endtask

	// Fill every slot, overflow once, free a few and allocate past them again.
	task automatic test_table_full();
		send_op(op_req(gsa_pkg::FN_CLEAR, '0, '0, '0, 1'b0));
		for (int i = 0; i < gsa_pkg::SLOT_COUNT; i++)
			send_op(op_req(gsa_pkg::FN_ALLOC, gsa_pkg::HSLOT_W'($urandom), $urandom,
				$urandom, 1'b1));
		send_op(op_req(gsa_pkg::FN_ALLOC, '0, '0, $urandom, 1'b1));
		send_op(op_req(gsa_pkg::FN_RESOLVE, 8'hff, mirror_gen[gsa_pkg::SLOT_COUNT - 1],
			'0, 1'b0));
		repeat (4)
			send_op(handle_op(gsa_pkg::FN_REMOVE));
		repeat (5)
			send_op(op_req(gsa_pkg::FN_ALLOC, gsa_pkg::HSLOT_W'($urandom), $urandom,
				$urandom, 1'b1));
	endtask

	// The receiver holds off for a long stretch while the sender keeps
	// offering beats back to back, so the block fills up and drops req_ready.
	task automatic test_backpressure();
		set_idle(0, 0);
		hold_left = 150;
		repeat (40)
			send_op(random_op());
	endtask

	task automatic test_random_ops(int unsigned count);
		repeat (count)
			send_op(random_op());
	endtask

	initial begin
		set_idle(37, 55);
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_alloc_resolve_basics();
		test_remove_and_reuse();
		test_clear();
		test_table_full();
		test_backpressure();

		set_idle(37, 55);
		test_random_ops(140);
		set_idle(55, 37);
		test_random_ops(140);
		set_idle(0, 0);
		test_random_ops(140);

		@(negedge clk);
		req_valid <= 1'b0;
		// Drain the owed replies, then wait for any stray beat.
		while (table_replies.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog: a correct run takes a small fraction of this time.
	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
